>>> rtl/core/text_window_char_writer_unit_assert.svh
// Assertion macros for the text window character writer.
`ifndef TEXT_WINDOW_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_WINDOW_CHAR_WRITER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition in this cycle implies consequence in the same cycle.
`define TWCW_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Condition in this cycle implies consequence in the next cycle.
`define TWCW_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define TWCW_ASSERT_SAME(label, cond, cons, msg)
`define TWCW_ASSERT_NEXT(label, cond, cons, msg)
`endif
`endif

>>> rtl/core/twcw_pkg.sv
// Shared types and constants of the text window character writer.
`default_nettype none
package twcw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_GLYPH  = 8'd32;

    typedef enum logic [2:0] {
        OP_PUT_CURSOR = 3'd0,
        OP_PUT_POS    = 3'd1,
        OP_SCROLL     = 3'd2,
        OP_READ       = 3'd3,
        OP_LOAD       = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_ATTR   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_NOP,
        K_NEWLINE,
        K_PUT_CURSOR,
        K_PUT_POS,
        K_SCROLL,
        K_READ,
        K_LOAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [6:0]  px;
        logic [4:0]  py;
        logic [7:0]  attr;
        logic        up;
        logic [5:0]  mag;
        logic [7:0]  tv;
    } t_cmd;

    typedef struct packed {
        logic [6:0] left;
        logic [4:0] top;
        logic [6:0] right;
        logic [4:0] bottom;
        logic [7:0] attr;
    } t_cfg;

    typedef struct packed {
        logic       vld;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] col;
        logic [4:0] row;
        logic       wrap;
    } t_res;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_WRITE,
        BS_READ_WAIT,
        BS_SC_RD,
        BS_SC_WR,
        BS_DONE
    } t_bstate;

endpackage
`default_nettype wire

>>> rtl/core/text_window_char_writer_unit.sv
// Top level of the text window character writer.
`default_nettype none
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  item in   | start / busy               | i_operation .. i_table_value
//  result    | o_result_valid (1 cycle)   | o_cell_char .. o_wrap_pending
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  After reset the cell store is swept to zero, one cell a cycle
//  (SCREEN_COLUMNS*SCREEN_ROWS cells, 2000 by default); busy stays high meanwhile.
//  Per item, from acceptance to strobe: the front register, the command queue, then
//  the back states idle, exec and done, with write before done for character writes
//  and read wait in place of done for a read. A scroll walks the window cells through
//  the single cell store, reading each source cell and then writing its destination;
//  a newline or wrap past the bottom row adds one such scroll. busy stays high until
//  the item has moved into the command queue, which waits while the queue is full.
//  The result strobe cannot be held off; results come out in item order.
module text_window_char_writer_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_pos_x,
    input  logic [4:0]        i_pos_y,
    input  logic [7:0]        i_put_attribute,
    input  logic signed [5:0] i_scroll_delta,
    input  logic [7:0]        i_table_value,
    output logic              o_result_valid,
    output logic [7:0]        o_cell_char,
    output logic [7:0]        o_cell_attribute,
    output logic [6:0]        o_cursor_col,
    output logic [4:0]        o_cursor_row,
    output logic              o_wrap_pending,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import twcw_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    t_res res;
    logic push, pop, q_full, q_empty, clearing;

    // config registers; the user must write them only while no item is in flight, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= 7'd0;
            r_cfg.top    <= 5'd0;
            r_cfg.right  <= 7'd79;
            r_cfg.bottom <= 5'd24;
            r_cfg.attr   <= 8'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[6:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[4:0];
                CFG_RIGHT:  r_cfg.right  <= i_cfg_data[6:0];
                CFG_BOTTOM: r_cfg.bottom <= i_cfg_data[4:0];
                CFG_ATTR:   r_cfg.attr   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // front: classify the item (newline, zero scroll, unused codes)
    twcw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_hold         (clearing),
        .i_operation    (i_operation),
        .i_char_code    (i_char_code),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_put_attribute(i_put_attribute),
        .i_scroll_delta (i_scroll_delta),
        .i_table_value  (i_table_value),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    twcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_cmd  (q_cmd)
    );

    // back: sequencer over the cell store and glyph table
    twcw_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_res     (res)
    );

    assign o_result_valid   = res.vld;
    assign o_cell_char      = res.cell_char;
    assign o_cell_attribute = res.cell_attr;
    assign o_cursor_col     = res.col;
    assign o_cursor_row     = res.row;
    assign o_wrap_pending   = res.wrap;

`include "text_window_char_writer_unit_assert.svh"

    `TWCW_ASSERT_SAME(a_no_result_in_clear, o_result_valid, !clearing, "result during clear")
    `TWCW_ASSERT_NEXT(a_strobe_single, o_result_valid, !o_result_valid, "result strobe > 1 cycle")
    `TWCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `TWCW_ASSERT_SAME(a_no_push_full, push, !q_full, "push into full queue")

endmodule
`default_nettype wire

>>> rtl/core/twcw_front.sv
// Front end: takes an item, classifies it and hands it to the queue.
`default_nettype none
module twcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_hold,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_pos_x,
    input  logic [4:0]        i_pos_y,
    input  logic [7:0]        i_put_attribute,
    input  logic signed [5:0] i_scroll_delta,
    input  logic [7:0]        i_table_value,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_push,
    output twcw_pkg::t_cmd    o_cmd
);
    import twcw_pkg::*;

    logic       r_vld, n_vld;
    t_cmd       r_cmd, n_cmd;
    logic       accept;
    logic [5:0] mag;

    assign o_busy = r_vld | i_hold;
    assign accept = i_start & ~o_busy;
    assign o_push = r_vld & ~i_q_full;
    assign o_cmd  = r_cmd;

    always_comb begin
        mag = i_scroll_delta[5] ? 6'(-i_scroll_delta) : 6'(i_scroll_delta);
        n_cmd      = r_cmd;
        n_vld      = r_vld;
        if (accept) begin
            n_vld      = 1'b1;
            n_cmd.ch   = i_char_code;
            n_cmd.px   = i_pos_x;
            n_cmd.py   = i_pos_y;
            n_cmd.attr = i_put_attribute;
            n_cmd.up   = ~i_scroll_delta[5];
            n_cmd.mag  = mag;
            n_cmd.tv   = i_table_value;
            case (i_operation)
                OP_PUT_CURSOR: n_cmd.kind = (i_char_code == NEWLINE_CODE) ? K_NEWLINE
                                                                           : K_PUT_CURSOR;
                OP_PUT_POS:    n_cmd.kind = K_PUT_POS;
                OP_SCROLL:     n_cmd.kind = (mag == 6'd0) ? K_NOP : K_SCROLL;
                OP_READ:       n_cmd.kind = K_READ;
                OP_LOAD:       n_cmd.kind = K_LOAD;
                default:       n_cmd.kind = K_NOP;
            endcase
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

>>> rtl/core/twcw_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module twcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  twcw_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output twcw_pkg::t_cmd o_cmd
);
    import twcw_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/twcw_back.sv
// Back end: cell store, glyph table, cursor and the operation sequencer.
`default_nettype none
module twcw_back #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  twcw_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  twcw_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output twcw_pkg::t_res o_res
);
    import twcw_pkg::*;

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam logic [7:0] SC8 = 8'(SCREEN_COLUMNS);
    localparam logic [7:0] SR8 = 8'(SCREEN_ROWS);

    logic [15:0] mem [CELLS];
    logic [7:0]  tbl [256];

    t_bstate     r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [6:0]  r_col, n_col;
    logic [4:0]  r_row, n_row;
    logic        r_wrap, n_wrap;
    logic        r_wrapped, n_wrapped;
    logic        r_up, n_up;
    logic [5:0]  r_d, n_d;
    logic [5:0]  r_i, n_i;
    logic [7:0]  r_x, n_x;
    logic        r_ret_write, n_ret_write;
    logic        r_blank, n_blank;
    logic        r_src_ok, n_src_ok;
    logic        r_rd_ok, n_rd_ok;
    logic [AW-1:0] r_clr, n_clr;
    t_res        r_res, n_res;
    logic [255:0] r_tvld;
    logic [7:0]  r_tbl_q;
    logic        r_tbl_hit;
    logic [15:0] r_mem_q;

    logic          mem_we, mem_re, tbl_we, tbl_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;

    logic [7:0] w;
    logic [5:0] h;
    logic       nl_over;
    logic       sc_start;
    logic       sc_up;
    logic [5:0] sc_mag;
    logic [6:0] s_rel;
    logic       s_blank;
    logic [7:0] a_col, a_row, d_row;
    logic [7:0] glyph;

    function automatic logic [AW-1:0] cell_addr(input logic [7:0] c, input logic [7:0] r);
        cell_addr = AW'(r[RW-1:0]) * AW'(SCREEN_COLUMNS) + AW'(c[CW-1:0]);
    endfunction

    function automatic logic on_screen(input logic [7:0] c, input logic [7:0] r);
        on_screen = (c < SC8) && (r < SR8);
    endfunction

    assign w = (i_cfg.right >= i_cfg.left) ? (8'(i_cfg.right) - 8'(i_cfg.left) + 8'd1) : 8'd1;
    assign h = (i_cfg.bottom >= i_cfg.top) ? (6'(i_cfg.bottom) - 6'(i_cfg.top) + 6'd1) : 6'd1;
    assign nl_over = ((6'(r_row) + 6'd1) >= h);
    assign glyph   = r_tbl_hit ? r_tbl_q : r_cmd.ch;

    assign o_clearing = (r_state == BS_CLEAR);
    assign o_res      = r_res;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_row       = r_row;
        n_wrap      = r_wrap;
        n_wrapped   = r_wrapped;
        n_up        = r_up;
        n_d         = r_d;
        n_i         = r_i;
        n_x         = r_x;
        n_ret_write = r_ret_write;
        n_blank     = r_blank;
        n_src_ok    = r_src_ok;
        n_rd_ok     = r_rd_ok;
        n_clr       = r_clr;
        n_res       = r_res;
        n_res.vld   = 1'b0;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        tbl_we      = 1'b0;
        tbl_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = '0;
        sc_start    = 1'b0;
        sc_up       = 1'b1;
        sc_mag      = 6'd1;
        s_rel       = '0;
        s_blank     = 1'b0;
        a_col       = 8'(i_cfg.left) + r_x;
        a_row       = '0;
        d_row       = 8'(i_cfg.top) + 8'(r_i);

        case (r_state)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = BS_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                case (r_cmd.kind)
                    K_LOAD: begin
                        tbl_we  = 1'b1;
                        n_state = BS_DONE;
                    end
                    K_READ: begin
                        a_col     = 8'(i_cfg.left) + 8'(r_cmd.px);
                        a_row     = 8'(i_cfg.top) + 8'(r_cmd.py);
                        n_rd_ok   = on_screen(a_col, a_row);
                        mem_re    = n_rd_ok;
                        mem_raddr = cell_addr(a_col, a_row);
                        n_state   = BS_READ_WAIT;
                    end
                    K_PUT_POS: begin
                        tbl_re  = 1'b1;
                        n_state = BS_WRITE;
                    end
                    K_SCROLL: begin
                        sc_start    = 1'b1;
                        sc_up       = r_cmd.up;
                        sc_mag      = r_cmd.mag;
                        n_ret_write = 1'b0;
                    end
                    K_NEWLINE: begin
                        n_wrap = 1'b0;
                        n_col  = '0;
                        if (nl_over) begin
                            n_row       = 5'(h - 6'd1);
                            sc_start    = 1'b1;
                            n_ret_write = 1'b0;
                        end else begin
                            n_row   = r_row + 5'd1;
                            n_state = BS_DONE;
                        end
                    end
                    K_PUT_CURSOR: begin
                        tbl_re    = 1'b1;
                        n_wrapped = r_wrap;
                        n_state   = BS_WRITE;
                        if (r_wrap) begin
                            // deferred wrap: newline first, then write at column 0
                            n_wrap = 1'b0;
                            n_col  = '0;
                            if (nl_over) begin
                                n_row       = 5'(h - 6'd1);
                                sc_start    = 1'b1;
                                n_ret_write = 1'b1;
                            end else begin
                                n_row = r_row + 5'd1;
                            end
                        end
                    end
                    default: n_state = BS_DONE;
                endcase
                if (sc_start) begin
                    n_up    = sc_up;
                    n_d     = (sc_mag > h) ? h : sc_mag;
                    n_i     = sc_up ? 6'd0 : (h - 6'd1);
                    n_x     = '0;
                    n_state = BS_SC_RD;
                end
            end
            BS_SC_RD: begin
                if (r_up) begin
                    s_rel   = 7'(r_i) + 7'(r_d);
                    s_blank = (s_rel >= 7'(h));
                end else begin
                    s_rel   = 7'(r_i) - 7'(r_d);
                    s_blank = (r_i < r_d);
                end
                a_row     = 8'(i_cfg.top) + 8'(s_rel);
                n_blank   = s_blank;
                n_src_ok  = ~s_blank & on_screen(a_col, a_row);
                mem_re    = n_src_ok;
                mem_raddr = cell_addr(a_col, a_row);
                n_state   = BS_SC_WR;
            end
            BS_SC_WR: begin
                mem_we    = on_screen(a_col, d_row);
                mem_waddr = cell_addr(a_col, d_row);
                mem_wdata = r_blank ? {BLANK_GLYPH, i_cfg.attr}
                                    : (r_src_ok ? r_mem_q : 16'd0);
                n_state   = BS_SC_RD;
                if (r_x == w - 8'd1) begin
                    n_x = '0;
                    if (r_up ? (r_i == h - 6'd1) : (r_i == 6'd0)) begin
                        n_state = r_ret_write ? BS_WRITE : BS_DONE;
                    end else begin
                        n_i = r_up ? (r_i + 6'd1) : (r_i - 6'd1);
                    end
                end else begin
                    n_x = r_x + 8'd1;
                end
            end
            BS_WRITE: begin
                if (r_cmd.kind == K_PUT_POS) begin
                    a_col     = 8'(i_cfg.left) + 8'(r_cmd.px);
                    a_row     = 8'(i_cfg.top) + 8'(r_cmd.py);
                    mem_wdata = {glyph, r_cmd.attr};
                end else begin
                    a_col     = 8'(i_cfg.left) + 8'(r_col);
                    a_row     = 8'(i_cfg.top) + 8'(r_row);
                    mem_wdata = {glyph, i_cfg.attr};
                    if (r_wrapped) begin
                        n_col  = 7'd1;
                        n_wrap = 1'b0;
                    end else if (8'(r_col) < w - 8'd1) begin
                        n_col = r_col + 7'd1;
                    end else begin
                        n_wrap = 1'b1;
                    end
                end
                mem_we    = on_screen(a_col, a_row);
                mem_waddr = cell_addr(a_col, a_row);
                n_state   = BS_DONE;
            end
            BS_READ_WAIT: begin
                n_res.vld       = 1'b1;
                n_res.cell_char = r_rd_ok ? r_mem_q[15:8] : 8'd0;
                n_res.cell_attr = r_rd_ok ? r_mem_q[7:0] : 8'd0;
                n_res.col       = r_col;
                n_res.row       = r_row;
                n_res.wrap      = r_wrap;
                n_state         = BS_IDLE;
            end
            BS_DONE: begin
                n_res.vld       = 1'b1;
                n_res.cell_char = 8'd0;
                n_res.cell_attr = 8'd0;
                n_res.col       = r_col;
                n_res.row       = r_row;
                n_res.wrap      = r_wrap;
                n_state         = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_wrap    <= 1'b0;
            r_res.vld <= 1'b0;
            r_tvld    <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_col   <= n_col;
            r_row   <= n_row;
            r_wrap  <= n_wrap;
            r_res   <= n_res;
            if (tbl_we) begin
                r_tvld[r_cmd.ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_wrapped   <= n_wrapped;
        r_up        <= n_up;
        r_d         <= n_d;
        r_i         <= n_i;
        r_x         <= n_x;
        r_ret_write <= n_ret_write;
        r_blank     <= n_blank;
        r_src_ok    <= n_src_ok;
        r_rd_ok     <= n_rd_ok;
    end

    // cell store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // glyph table; an entry never loaded reads as its own index
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl[r_cmd.ch] <= r_cmd.tv;
        end
        if (tbl_re) begin
            r_tbl_q   <= tbl[r_cmd.ch];
            r_tbl_hit <= r_tvld[r_cmd.ch];
        end
    end

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the text window character writer: predicts every result.
`timescale 1ns / 100ps
`default_nettype none

import twcw_pkg::*;

// Golden screen model plus the queue of results still owed by the block.
class screen_tracker;
    localparam int COLS = 80;
    localparam int ROWS = 25;

    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
        logic       wrap;
    } t_view;

    logic [7:0] glyph_mem [COLS*ROWS];
    logic [7:0] attr_mem  [COLS*ROWS];
    logic [7:0] xlat [256];
    int unsigned cur_col, cur_row, wrap_flag;
    int unsigned win_l, win_t, win_r, win_b, cur_attr;
    t_view pending_views [$];
    int errors;

    function new();
        for (int i = 0; i < COLS*ROWS; i++) begin
            glyph_mem[i] = 0;
            attr_mem[i] = 0;
        end
        for (int i = 0; i < 256; i++) xlat[i] = i[7:0];
        cur_col = 0; cur_row = 0; wrap_flag = 0;
        win_l = 0; win_t = 0; win_r = 79; win_b = 24; cur_attr = 7;
        errors = 0;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [7:0] val);
        case (idx)
            CFG_LEFT:   win_l = val & 8'h7f;
            CFG_TOP:    win_t = val & 8'h1f;
            CFG_RIGHT:  win_r = val & 8'h7f;
            CFG_BOTTOM: win_b = val & 8'h1f;
            CFG_ATTR:   cur_attr = val;
            default: ;
        endcase
    endfunction

    function int unsigned width_of();
        return (win_r >= win_l) ? win_r - win_l + 1 : 1;
    endfunction

    function int unsigned height_of();
        return (win_b >= win_t) ? win_b - win_t + 1 : 1;
    endfunction

    function void poke(int unsigned c, int unsigned r, logic [7:0] g, logic [7:0] a);
        if (c >= COLS || r >= ROWS) return;
        glyph_mem[r*COLS+c] = g;
        attr_mem[r*COLS+c] = a;
    endfunction

    function void peek(int unsigned c, int unsigned r, output logic [7:0] g,
                       output logic [7:0] a);
        g = 0; a = 0;
        if (c >= COLS || r >= ROWS) return;
        g = glyph_mem[r*COLS+c];
        a = attr_mem[r*COLS+c];
    endfunction

    function void move_row(int unsigned dst, int unsigned src);
        logic [7:0] g, a;
        for (int unsigned x = 0; x < width_of(); x++) begin
            peek(win_l + x, win_t + src, g, a);
            poke(win_l + x, win_t + dst, g, a);
        end
    endfunction

    function void blank_line(int unsigned r);
        for (int unsigned x = 0; x < width_of(); x++)
            poke(win_l + x, win_t + r, BLANK_GLYPH, cur_attr[7:0]);
    endfunction

    function void scroll(int delta);
        int unsigned h, d;
        h = height_of();
        if (delta == 0) return;
        d = (delta > 0) ? delta : -delta;
        if (d > h) d = h;
        if (delta > 0) begin
            for (int unsigned i = 0; i + d < h; i++) move_row(i, i + d);
            for (int unsigned i = h - d; i < h; i++) blank_line(i);
        end else begin
            for (int unsigned i = h; i > d; i--) move_row(i - 1, i - 1 - d);
            for (int unsigned i = 0; i < d; i++) blank_line(i);
        end
    endfunction

    function void line_feed();
        wrap_flag = 0;
        cur_col = 0;
        cur_row++;
        if (cur_row >= height_of()) begin
            cur_row = height_of() - 1;
            scroll(1);
        end
    endfunction

    function void put_cursor(logic [7:0] ch);
        if (ch == NEWLINE_CODE) begin
            line_feed();
        end else if (!wrap_flag && cur_col < width_of() - 1) begin
            poke(win_l + cur_col, win_t + cur_row, xlat[ch], cur_attr[7:0]);
            cur_col++;
        end else if (!wrap_flag) begin
            poke(win_l + cur_col, win_t + cur_row, xlat[ch], cur_attr[7:0]);
            wrap_flag = 1;
        end else begin
            line_feed();
            poke(win_l + cur_col, win_t + cur_row, xlat[ch], cur_attr[7:0]);
            cur_col++;
            wrap_flag = 0;
        end
    endfunction

    // Accepted input item: apply it and queue the expected result.
    function void note_item(logic [2:0] op, logic [7:0] ch, logic [6:0] px, logic [4:0] py,
                            logic [7:0] pa, logic signed [5:0] sd, logic [7:0] tv);
        t_view v;
        logic [7:0] g, a;
        g = 0; a = 0;
        case (op)
            OP_PUT_CURSOR: put_cursor(ch);
            OP_PUT_POS:    poke(win_l + px, win_t + py, xlat[ch], pa);
            OP_SCROLL:     scroll(int'(sd));
            OP_READ:       peek(win_l + px, win_t + py, g, a);
            OP_LOAD:       xlat[ch] = tv;
            default: ;
        endcase
        v.glyph = g; v.attr = a;
        v.col = cur_col[6:0]; v.row = cur_row[4:0]; v.wrap = wrap_flag[0];
        pending_views.push_back(v);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(logic [7:0] g, logic [7:0] a, logic [6:0] c, logic [4:0] r,
                      logic w);
        t_view v;
        if (pending_views.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
        end
        v = pending_views.pop_front();
        if (g !== v.glyph) report("cell_char", g, v.glyph);
        if (a !== v.attr)  report("cell_attribute", a, v.attr);
        if (c !== v.col)   report("cursor_col", c, v.col);
        if (r !== v.row)   report("cursor_row", r, v.row);
        if (w !== v.wrap)  report("wrap_pending", w, v.wrap);
    endtask
endclass

module testbench;
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [2:0]        i_operation = 0;
    logic [7:0]        i_char_code = 0;
    logic [6:0]        i_pos_x = 0;
    logic [4:0]        i_pos_y = 0;
    logic [7:0]        i_put_attribute = 0;
    logic signed [5:0] i_scroll_delta = 0;
    logic [7:0]        i_table_value = 0;
    logic              o_result_valid;
    logic [7:0]        o_cell_char;
    logic [7:0]        o_cell_attribute;
    logic [6:0]        o_cursor_col;
    logic [4:0]        o_cursor_row;
    logic              o_wrap_pending;
    logic              i_cfg_valid = 0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = 0;
    logic [7:0]        i_cfg_data = 0;

    screen_tracker screen = new();

    text_window_char_writer_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Results cannot be stalled: sample every strobe at the edge.
    always @(posedge i_clk)
        if (i_rst_n && o_result_valid)
            screen.check_result(o_cell_char, o_cell_attribute, o_cursor_col, o_cursor_row,
                                o_wrap_pending);

    // Model is updated at the accepting edge, so expectations are in item order.
    always @(posedge i_clk)
        if (i_rst_n && start && !busy)
            screen.note_item(i_operation, i_char_code, i_pos_x, i_pos_y, i_put_attribute,
                             i_scroll_delta, i_table_value);

    // Worst case: a scroll of a full screen for every item, plus the sweep.
    initial begin
        #400ms;
        $display("[text_window_char_writer_unit] ERROR");
        $finish;
    end

    // Offer one item after a random gap (none if no_gap is set) and hold it until it is taken.
    // start stays high after the accepting edge; drain() or a next call with a gap drops it.
    task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [6:0] px, logic [4:0] py,
                             logic [7:0] pa, logic signed [5:0] sd, logic [7:0] tv,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 19));
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_operation <= op; i_char_code <= ch; i_pos_x <= px; i_pos_y <= py;
        i_put_attribute <= pa; i_scroll_delta <= sd; i_table_value <= tv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Wait for every owed result, then let the block settle.
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (screen.pending_views.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        screen.set_reg(idx, val);
    endtask

    task automatic set_window(int l, int t, int r, int b, int a);
        drain();
        write_reg(CFG_LEFT, 8'(l));
        write_reg(CFG_TOP, 8'(t));
        write_reg(CFG_RIGHT, 8'(r));
        write_reg(CFG_BOTTOM, 8'(b));
        write_reg(CFG_ATTR, 8'(a));
        i_cfg_valid <= 0;
    endtask

    // Random item; mostly text with newlines so the cursor wraps and scrolls.
    task automatic random_item(int wmax, int hmax);
        int pick;
        logic [7:0] ch;
        pick = int'($urandom_range(0, 99));
        ch = 8'($urandom);
        if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) ch = NEWLINE_CODE;
            send_item(OP_PUT_CURSOR, ch, 7'($urandom), 5'($urandom), 8'($urandom),
                      6'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
        end else if (pick < 60) begin
            send_item(OP_PUT_POS, ch, 7'($urandom_range(0, wmax)),
                      5'($urandom_range(0, hmax)), 8'($urandom), 6'($urandom),
                      8'($urandom));
        end else if (pick < 80) begin
            send_item(OP_READ, ch, 7'($urandom_range(0, wmax)),
                      5'($urandom_range(0, hmax)), 8'($urandom), 6'($urandom),
                      8'($urandom));
        end else if (pick < 86) begin
            send_item(OP_SCROLL, ch, 7'($urandom), 5'($urandom), 8'($urandom),
                      6'(int'($urandom_range(0, 6)) - 3), 8'($urandom));
        end else if (pick < 90) begin
            send_item(OP_SCROLL, ch, 7'($urandom), 5'($urandom), 8'($urandom),
                      6'($urandom), 8'($urandom));
        end else if (pick < 96) begin
            send_item(OP_LOAD, ch, 7'($urandom), 5'($urandom), 8'($urandom),
                      6'($urandom), 8'($urandom));
        end else begin
            send_item(3'($urandom_range(5, 7)), ch, 7'($urandom), 5'($urandom),
                      8'($urandom), 6'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int l, t, r, b;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: full screen, extremes of every field and each operation.
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_PUT_POS, 8'hff, 79, 24, 8'hff, 0, 0);
        send_item(OP_READ, 0, 79, 24, 0, 0, 0);
        send_item(OP_PUT_POS, 8'h41, 127, 31, 8'h12, 0, 0);   // off screen, ignored
        send_item(OP_READ, 0, 127, 31, 0, 0, 0);              // off screen read
        send_item(OP_LOAD, 8'h41, 0, 0, 0, 0, 8'hc3);
        send_item(OP_PUT_CURSOR, 8'h41, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_PUT_CURSOR, NEWLINE_CODE, 0, 0, 0, 0, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, 6'sd25, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, -6'sd25, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, 6'sd31, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, -6'sd32, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, 0, 0);
        send_item(3'd7, 8'hff, 127, 31, 8'hff, 6'sd31, 8'hff);

        // Tiny window: deferred wrap, wrap past bottom row, degenerate sizes.
        set_window(78, 23, 79, 24, 8'hff);
        for (int i = 0; i < 8; i++) send_item(OP_PUT_CURSOR, 8'(8'h30 + i), 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 1, 1, 0, 0, 0);
        set_window(5, 9, 2, 3, 0);                            // reversed: 1x1
        for (int i = 0; i < 4; i++) send_item(OP_PUT_CURSOR, 8'(8'h61 + i), 0, 0, 0, 0, 0);
        send_item(OP_PUT_CURSOR, NEWLINE_CODE, 0, 0, 0, 0, 0);
        set_window(127, 31, 127, 31, 8'h5a);                  // window off screen
        send_item(OP_PUT_CURSOR, 8'h62, 0, 0, 0, 0, 0);
        send_item(OP_SCROLL, 0, 0, 0, 0, -6'sd1, 0);
        drain();                                              // sender waits for all results

        // Random phases over several windows, mostly small so scrolls stay cheap.
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                l = 0; t = 0; r = 79; b = 24;
            end else if (phase == 11) begin
                l = $urandom_range(0, 127); t = $urandom_range(0, 31);
                r = $urandom_range(0, 127); b = $urandom_range(0, 31);
            end else begin
                l = $urandom_range(0, 76); t = $urandom_range(0, 22);
                r = l + $urandom_range(0, 7); b = t + $urandom_range(0, 3);
                if (r > 79) r = 79;
                if (b > 24) b = 24;
            end
            set_window(l, t, r, b, $urandom_range(0, 255));
            for (int i = 0; i < (phase == 0 ? 60 : 105); i++)
                random_item((r >= l ? r - l : 0) + 1, (b >= t ? b - t : 0) + 1);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (screen.errors == 0 && screen.pending_views.size() == 0) begin
            $display("[text_window_char_writer_unit] OK");
        end else begin
            $display("[text_window_char_writer_unit] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/twcw_pkg.sv
rtl/core/twcw_front.sv
rtl/core/twcw_queue.sv
rtl/core/twcw_back.sv
rtl/core/text_window_char_writer_unit.sv
bench/testbench.sv
